### src/mux_scan_median_sampler_top_macros.svh
// mux_scan_median_sampler_top_macros.svh: assertion macros for the sampler RTL.
// Depends on clk and rst_n being in scope where a macro is used.
`ifndef MUX_SCAN_MEDIAN_SAMPLER_TOP_MACROS_SVH
`define MUX_SCAN_MEDIAN_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define MSMS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msms: assertion failed");
`define MSMS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msms: assertion failed");
`else
`define MSMS_ASSERT_IMP(lbl, ante, cons)
`define MSMS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### src/msms_pkg.sv
// msms_pkg: constants, codes and interface structs of the mux scan median sampler.
// No dependencies; used by msms_median, mux_scan_median_sampler_top and the bench.
`timescale 1ns / 1ps

package msms_pkg;

  localparam int SAMPLES_PER_READ = 7;
  localparam int ADC_CHANNELS     = 4;
  localparam int MUX_POSITIONS    = 8;

  localparam int SAMPLE_W    = 16;
  localparam int POS_W       = 3;
  localparam int CH_W        = 2;
  localparam int IDX_W       = 5;
  localparam int STORE_DEPTH = 32;
  localparam int MASK_W      = 32;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  localparam int MED_IDX = (SAMPLES_PER_READ - 1) / 2;
  localparam int CNT_W   = $clog2(SAMPLES_PER_READ);
  localparam int RANK_W  = $clog2(SAMPLES_PER_READ + 1);

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_TICK_BUSY   = 2'd1,
    STS_SAMPLE_IDLE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MEDIAN
  } top_state_t;

  typedef enum logic {
    MS_IDLE,
    MS_COUNT
  } med_state_t;

  typedef struct packed {
    logic                shift;
    logic                start;
    logic [SAMPLE_W-1:0] sample;
  } med_ctl_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] median;
  } med_sts_t;

endpackage

### src/msms_ram.sv
// msms_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module msms_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

### src/msms_median.sv
// msms_median: sample ring and median search with one shared signed comparator.
// Depends on msms_pkg and mux_scan_median_sampler_top_macros.svh.
`timescale 1ns / 1ps
`include "mux_scan_median_sampler_top_macros.svh"

module msms_median (
  input  logic               clk,
  input  logic               rst_n,
  input  msms_pkg::med_ctl_t ctl,
  output msms_pkg::med_sts_t sts
);

  localparam int S      = msms_pkg::SAMPLES_PER_READ;
  localparam int DW     = msms_pkg::SAMPLE_W;
  localparam int RANK_W = msms_pkg::RANK_W;
  localparam int STEP_W = msms_pkg::CNT_W;

  msms_pkg::med_state_t ms_r, ms_nxt;

  logic [DW-1:0]     ring_r [S];
  logic [DW-1:0]     ring_nxt [S];
  logic [DW-1:0]     cand_r, cand_nxt;
  logic [RANK_W-1:0] less_r, less_nxt;
  logic [RANK_W-1:0] leq_r, leq_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              is_first, is_last, lt, eq, hit_lt, hit_le, found;
  logic [RANK_W-1:0] less_sum, leq_sum;

  // Shared compare: ring head against the held candidate; step 0 is the candidate itself.
  always_comb begin
    is_first = (step_r == '0);
    is_last  = (step_r == STEP_W'(S - 1));
    lt       = $signed(ring_r[0]) < $signed(cand_r);
    eq       = (ring_r[0] == cand_r);
    hit_lt   = is_first ? 1'b0 : lt;
    hit_le   = is_first ? 1'b1 : (lt | eq);
    less_sum = (is_first ? '0 : less_r) + RANK_W'(hit_lt);
    leq_sum  = (is_first ? '0 : leq_r) + RANK_W'(hit_le);
    found    = is_last && (less_sum <= RANK_W'(msms_pkg::MED_IDX)) &&
               (leq_sum > RANK_W'(msms_pkg::MED_IDX));
  end

  // Next state
  always_comb begin
    ms_nxt = ms_r;
    case (ms_r)
      msms_pkg::MS_IDLE: begin
        if (ctl.start) begin
          ms_nxt = msms_pkg::MS_COUNT;
        end
      end
      msms_pkg::MS_COUNT: begin
        if (found) begin
          ms_nxt = msms_pkg::MS_IDLE;
        end
      end
      default: ms_nxt = msms_pkg::MS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    sts.done   = (ms_r == msms_pkg::MS_COUNT) && found;
    sts.median = cand_r;
  end

  // Datapath: shift in samples, rotate the ring while ranking a candidate
  always_comb begin
    ring_nxt = ring_r;
    cand_nxt = cand_r;
    less_nxt = less_r;
    leq_nxt  = leq_r;
    step_nxt = step_r;
    if (ctl.shift) begin
      for (int i = 0; i < S - 1; i++) begin
        ring_nxt[i] = ring_r[i + 1];
      end
      ring_nxt[S - 1] = ctl.sample;
    end
    if (ctl.start) begin
      step_nxt = '0;
    end
    if (ms_r == msms_pkg::MS_COUNT) begin
      less_nxt = less_sum;
      leq_nxt  = leq_sum;
      if (is_first) begin
        cand_nxt = ring_r[0];
      end
      if (is_last) begin
        // advance two places so the next pass starts one entry further on
        step_nxt = '0;
        for (int i = 0; i < S; i++) begin
          ring_nxt[i] = ring_r[(i + 2) % S];
        end
      end else begin
        step_nxt = step_r + STEP_W'(1);
        for (int i = 0; i < S; i++) begin
          ring_nxt[i] = ring_r[(i + 1) % S];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r   <= msms_pkg::MS_IDLE;
      step_r <= '0;
    end else begin
      ms_r   <= ms_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ring_r <= ring_nxt;
    cand_r <= cand_nxt;
    less_r <= less_nxt;
    leq_r  <= leq_nxt;
  end

  `MSMS_ASSERT_IMP(a_start_when_idle, ctl.start, ms_r == msms_pkg::MS_IDLE)
  `MSMS_ASSERT_NXT(a_done_single, sts.done, !sts.done)
  `MSMS_ASSERT_IMP(a_rank_order, (ms_r == msms_pkg::MS_COUNT) && (step_r != '0), leq_r > less_r)

endmodule

### src/mux_scan_median_sampler_top.sv
// mux_scan_median_sampler_top: scan sequencer for an 8-way mux and 4-channel converter.
// Tick/sample results go straight into the result register; reads load it in ST_READ, with
// in_tready low. Ticks and samples 1 per cycle while the result slot is free or draining; the
// final sample of a channel holds in_tready low while the shared comparator ranks candidates.
// Reset (sync, rst_n low): clear scan state, mask and store valid bits; no clearing pass.
// Depends on msms_pkg, msms_median, msms_ram and mux_scan_median_sampler_top_macros.svh.
`timescale 1ns / 1ps
`include "mux_scan_median_sampler_top_macros.svh"

module mux_scan_median_sampler_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration: enable_mask
  input  logic                                cfg_wen,
  input  logic [msms_pkg::MASK_W-1:0]         cfg_wdata,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [msms_pkg::IN_TDATA_W-1:0]     in_tdata,   // [15:0] sample_value, [20:16] read_index
  input  logic [1:0]                          in_tuser,   // [1:0] opcode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [msms_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [2:0] mux_address, [3] request_valid,
                                                          // [5:4] request_channel, [6] scan_done,
                                                          // [22:7] read_value
  output logic [1:0]                          out_tuser   // [1:0] status
);

  localparam int DW    = msms_pkg::SAMPLE_W;
  localparam int POS_W = msms_pkg::POS_W;
  localparam int CH_W  = msms_pkg::CH_W;
  localparam int IDX_W = msms_pkg::IDX_W;
  localparam int CNT_W = msms_pkg::CNT_W;

  // ---------------------------------------------------------------------------
  // Channel search: first enabled channel at or above 'from' for position 'pos'.
  // Result bit 2 flags a hit, bits 1:0 carry the channel.
  // ---------------------------------------------------------------------------
  function automatic logic [CH_W:0] find_chan(logic [msms_pkg::MASK_W-1:0] mask,
                                              logic [POS_W-1:0] pos,
                                              logic [CH_W:0] from);
    logic [CH_W:0] r;
    r = '0;
    // walk downward so the lowest enabled channel wins
    for (int c = msms_pkg::ADC_CHANNELS - 1; c >= 0; c--) begin
      if ((3'(c) >= from) && mask[{2'(c), pos}]) begin
        r = {1'b1, 2'(c)};
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  msms_pkg::top_state_t state_r, state_nxt;

  logic [msms_pkg::MASK_W-1:0]      mask_r;
  logic [POS_W-1:0]                 pos_r, pos_nxt;
  logic                             gath_r, gath_nxt;
  logic [CH_W-1:0]                  chan_r, chan_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic [IDX_W-1:0]                 slot_r, slot_nxt;       // store slot of the median in flight
  logic [IDX_W-1:0]                 rd_idx_r, rd_idx_nxt;   // slot of the read in flight
  logic [msms_pkg::STORE_DEPTH-1:0] valid_r, valid_nxt;     // store entries written since reset

  // result register
  logic                   out_valid_r, out_valid_nxt;
  msms_pkg::status_t      out_status_r, out_status_nxt;
  logic [POS_W-1:0]       out_addr_r, out_addr_nxt;
  logic                   out_req_r, out_req_nxt;
  logic [CH_W-1:0]        out_ch_r, out_ch_nxt;
  logic                   out_done_r, out_done_nxt;
  logic [DW-1:0]          out_val_r, out_val_nxt;

  // ---------------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------------
  msms_pkg::opcode_t opcode;
  logic [DW-1:0]     in_sample;
  logic [IDX_W-1:0]  in_ridx;
  logic              in_fire;

  assign opcode    = msms_pkg::opcode_t'(in_tuser[1:0]);
  assign in_sample = in_tdata[DW-1:0];
  assign in_ridx   = in_tdata[DW+IDX_W-1:DW];
  assign in_fire   = in_tvalid && in_tready;

  // median unit and value store
  msms_pkg::med_ctl_t med_ctl;
  msms_pkg::med_sts_t med_sts;
  logic               ram_we;
  logic [DW-1:0]      ram_rdata;

  // sequencer controls
  logic out_load_imm, out_load_rd;

  // per-transaction results
  msms_pkg::status_t res_status;
  logic              res_done;
  logic [CH_W:0]     sel;
  logic [POS_W-1:0]  adv_pos;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msms_pkg::ST_IDLE: begin
        if (in_fire && (opcode == msms_pkg::OP_READ)) begin
          state_nxt = msms_pkg::ST_READ;
        end else if (med_ctl.start) begin
          state_nxt = msms_pkg::ST_MEDIAN;
        end
      end
      msms_pkg::ST_READ: begin
        state_nxt = msms_pkg::ST_IDLE;
      end
      msms_pkg::ST_MEDIAN: begin
        if (med_sts.done) begin
          state_nxt = msms_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msms_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    // accept while idle and the result slot is free or draining this cycle
    in_tready    = (state_r == msms_pkg::ST_IDLE) && (!out_valid_r || out_tready);
    out_load_imm = in_fire && (opcode != msms_pkg::OP_READ);
    out_load_rd  = (state_r == msms_pkg::ST_READ);
    ram_we       = (state_r == msms_pkg::ST_MEDIAN) && med_sts.done;
  end

  // ---------------------------------------------------------------------------
  // Scan datapath
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt        = pos_r;
    gath_nxt       = gath_r;
    chan_nxt       = chan_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    rd_idx_nxt     = rd_idx_r;
    res_status     = msms_pkg::STS_OK;
    res_done       = 1'b0;
    sel            = '0;
    med_ctl.shift  = 1'b0;
    med_ctl.start  = 1'b0;
    med_ctl.sample = in_sample;
    // wrap the position at the last mux input
    adv_pos = (pos_r == POS_W'(msms_pkg::MUX_POSITIONS - 1)) ? '0 : pos_r + POS_W'(1);

    if (in_fire) begin
      case (opcode)
        msms_pkg::OP_TICK: begin
          if (gath_r) begin
            res_status = msms_pkg::STS_TICK_BUSY;
          end else begin
            sel = find_chan(mask_r, pos_r, '0);
            if (sel[CH_W]) begin
              gath_nxt  = 1'b1;
              chan_nxt  = sel[CH_W-1:0];
              count_nxt = '0;
            end else begin
              // nothing enabled here: advance at once
              pos_nxt  = adv_pos;
              res_done = 1'b1;
            end
          end
        end
        msms_pkg::OP_SAMPLE: begin
          if (!gath_r) begin
            res_status = msms_pkg::STS_SAMPLE_IDLE;
          end else begin
            med_ctl.shift = 1'b1;
            if (count_r == CNT_W'(msms_pkg::SAMPLES_PER_READ - 1)) begin
              // last sample: launch the median, move to the next enabled channel or on to the next position
              med_ctl.start = 1'b1;
              slot_nxt      = {chan_r, pos_r};
              count_nxt     = '0;
              sel           = find_chan(mask_r, pos_r, {1'b0, chan_r} + 3'd1);
              if (sel[CH_W]) begin
                chan_nxt = sel[CH_W-1:0];
              end else begin
                gath_nxt = 1'b0;
                chan_nxt = '0;
                pos_nxt  = adv_pos;
                res_done = 1'b1;
              end
            end else begin
              count_nxt = count_r + CNT_W'(1);
            end
          end
        end
        msms_pkg::OP_READ: begin
          rd_idx_nxt = in_ridx;
        end
        default: ;  // unused opcode: no effect
      endcase
    end
  end

  // store valid bits: an unwritten entry reads as zero
  always_comb begin
    valid_nxt = valid_r;
    if (ram_we) begin
      valid_nxt[slot_r] = 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_req_nxt    = out_req_r;
    out_ch_nxt     = out_ch_r;
    out_done_nxt   = out_done_r;
    out_val_nxt    = out_val_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load_imm) begin
      // report the request that stands after this transaction
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status;
      out_addr_nxt   = pos_r;
      out_req_nxt    = gath_nxt;
      out_ch_nxt     = gath_nxt ? chan_nxt : '0;
      out_done_nxt   = res_done;
      out_val_nxt    = '0;
    end else if (out_load_rd) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = msms_pkg::STS_OK;
      out_addr_nxt   = pos_r;
      out_req_nxt    = gath_r;
      out_ch_nxt     = gath_r ? chan_r : '0;
      out_done_nxt   = 1'b0;
      out_val_nxt    = valid_r[rd_idx_r] ? ram_rdata : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= msms_pkg::ST_IDLE;
      mask_r      <= '0;
      pos_r       <= '0;
      gath_r      <= 1'b0;
      chan_r      <= '0;
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      gath_r      <= gath_nxt;
      chan_r      <= chan_nxt;
      count_r     <= count_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        mask_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_req_r    <= out_req_nxt;
    out_ch_r     <= out_ch_nxt;
    out_done_r   <= out_done_nxt;
    out_val_r    <= out_val_nxt;
  end

  // ---------------------------------------------------------------------------
  // Median unit and value store
  // ---------------------------------------------------------------------------
  msms_median u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (med_ctl),
    .sts   (med_sts)
  );

  msms_ram #(
    .WIDTH (DW),
    .DEPTH (msms_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (med_sts.median),
    .raddr (in_ridx),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Ports
  // ---------------------------------------------------------------------------
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r, out_done_r, out_ch_r, out_req_r, out_addr_r};
  assign out_tuser  = out_status_r;

  `MSMS_ASSERT_IMP(a_done_in_median, med_sts.done, state_r == msms_pkg::ST_MEDIAN)
  `MSMS_ASSERT_NXT(a_read_result, state_r == msms_pkg::ST_READ, out_tvalid)
  `MSMS_ASSERT_IMP(a_idle_count_zero, !gath_r, count_r == '0)
  `MSMS_ASSERT_IMP(a_done_no_request, out_tvalid && out_done_r, !out_req_r)

endmodule

### bench/tb_mux_scan_median_sampler_top.sv
// tb_mux_scan_median_sampler_top: self-checking bench for the mux scan median sampler.
// Predicts every result from its own scan model and compares it field by field.
// Depends on msms_pkg and mux_scan_median_sampler_top.
`timescale 1ns / 1ps

module tb_mux_scan_median_sampler_top;
  import msms_pkg::*;

  // Opcode value the block leaves unused; it must answer with no effect.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Cycles to let pass after the last result before touching the mask or ending.
  // Covers the longest median search, which runs on after its result is out.
  localparam int SETTLE_CYCLES = 64;
  // Cycles with no transaction on any port before the run is declared hung.
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [1:0]          opcode;
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    index;
  } scan_item_t;

  typedef struct {
    status_t             status;
    logic [POS_W-1:0]    addr;
    logic                req_valid;
    logic [CH_W-1:0]     req_chan;
    logic                done;
    logic [SAMPLE_W-1:0] value;
  } scan_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wen = 1'b0;
  logic [MASK_W-1:0]      cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [1:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  // Scan model: mask, position, gathering flag, channel, sample count, window, store.
  logic [MASK_W-1:0]   sim_mask = '0;
  logic [POS_W-1:0]    sim_pos = '0;
  logic                sim_gathering = 1'b0;
  logic [CH_W-1:0]     sim_chan = '0;
  int                  sim_count = 0;
  logic [SAMPLE_W-1:0] sim_window [SAMPLES_PER_READ];
  logic [SAMPLE_W-1:0] sim_store [STORE_DEPTH];

  scan_result_t pending_results [$];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int medians_stored = 0;
  int positions_done = 0;
  int mask_writes = 0;
  int stall_cycles = 0;

  mux_scan_median_sampler_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 2 ns clock: high 1 ns, low 1 ns.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: stall at random, redrawn on each falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog: end the run if no transaction of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles at %0t", STALL_LIMIT, $time);
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) sim_store[i] = '0;
    for (int i = 0; i < SAMPLES_PER_READ; i++) sim_window[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Scan model
  // ---------------------------------------------------------------------------

  // First enabled channel at or above 'from' for the current position, or -1.
  function automatic int next_enabled_channel(input int from);
    for (int ch = from; ch < ADC_CHANNELS; ch++) begin
      if (sim_mask[ch * MUX_POSITIONS + sim_pos]) return ch;
    end
    return -1;
  endfunction

  // Sort the window as signed values and take the lower middle entry.
  function automatic logic [SAMPLE_W-1:0] window_median();
    logic signed [SAMPLE_W-1:0] s [SAMPLES_PER_READ];
    logic signed [SAMPLE_W-1:0] key;
    int j;
    for (int i = 0; i < SAMPLES_PER_READ; i++) s[i] = sim_window[i];
    for (int i = 1; i < SAMPLES_PER_READ; i++) begin
      key = s[i];
      j = i - 1;
      while (j >= 0 && s[j] > key) begin
        s[j + 1] = s[j];
        j--;
      end
      s[j + 1] = key;
    end
    return s[MED_IDX];
  endfunction

  function automatic void step_position();
    sim_pos = (sim_pos == MUX_POSITIONS - 1) ? '0 : sim_pos + 1'b1;
    positions_done++;
  endfunction

  // Advance the model by one accepted item and return the result it causes.
  function automatic void predict_scan_result(input scan_item_t it, output scan_result_t r);
    int ch;
    r.status = STS_OK;
    r.addr   = sim_pos;
    r.done   = 1'b0;
    r.value  = '0;
    case (it.opcode)
      OP_TICK: begin
        if (sim_gathering) begin
          r.status = STS_TICK_BUSY;
        end else begin
          ch = next_enabled_channel(0);
          if (ch >= 0) begin
            sim_gathering = 1'b1;
            sim_chan = ch[CH_W-1:0];
            sim_count = 0;
          end else begin
            step_position();
            r.done = 1'b1;
          end
        end
      end
      OP_SAMPLE: begin
        if (!sim_gathering) begin
          r.status = STS_SAMPLE_IDLE;
        end else begin
          sim_window[sim_count] = it.sample;
          sim_count++;
          if (sim_count >= SAMPLES_PER_READ) begin
            sim_store[{sim_chan, sim_pos}] = window_median();
            medians_stored++;
            sim_count = 0;
            // The channel search sees the mask as it stands right now.
            ch = next_enabled_channel(sim_chan + 1);
            if (ch >= 0) begin
              sim_chan = ch[CH_W-1:0];
            end else begin
              sim_gathering = 1'b0;
              sim_chan = '0;
              step_position();
              r.done = 1'b1;
            end
          end
        end
      end
      OP_READ: r.value = sim_store[it.index];
      default: ;
    endcase
    r.req_valid = sim_gathering;
    r.req_chan  = sim_gathering ? sim_chan : '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got 0x%0h, expected 0x%0h at %0t", what, got, want, $time);
  endtask

  // Compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_tdata), 32'd0);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_tuser != want.status)
          flag_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[2:0] != want.addr)
          flag_mismatch("mux_address", 32'(out_tdata[2:0]), 32'(want.addr));
        if (out_tdata[3] != want.req_valid)
          flag_mismatch("request_valid", 32'(out_tdata[3]), 32'(want.req_valid));
        if (out_tdata[5:4] != want.req_chan)
          flag_mismatch("request_channel", 32'(out_tdata[5:4]), 32'(want.req_chan));
        if (out_tdata[6] != want.done)
          flag_mismatch("scan_done", 32'(out_tdata[6]), 32'(want.done));
        if (out_tdata[22:7] != want.value)
          flag_mismatch("read_value", 32'(out_tdata[22:7]), 32'(want.value));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until accepted, then record its prediction.
  task automatic send_item(input logic [1:0] op, input logic [SAMPLE_W-1:0] smp,
                           input logic [IDX_W-1:0] idx);
    scan_item_t it;
    scan_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, idx, smp};
    do @(posedge clk); while (!in_tready);
    it.opcode = op;
    it.sample = smp;
    it.index  = idx;
    predict_scan_result(it, r);
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Drop the input, wait for every prediction to be matched, then let the block settle.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write enable_mask; call only once the block is drained.
  task automatic write_enable_mask(input logic [MASK_W-1:0] mask);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= mask;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    sim_mask = mask;
    mask_writes++;
  endtask

  function automatic logic [SAMPLE_W-1:0] random_sample();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      case ($urandom_range(0, 3))
        0: return 16'h8000;
        1: return 16'h7FFF;
        2: return 16'h0000;
        default: return 16'hFFFF;
      endcase
    end
    // Narrow values make ties in the window likely.
    if (roll < 40) return 16'($urandom_range(0, 8) - 4);
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [MASK_W-1:0] random_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom() & $urandom() & $urandom();  // sparse
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle behavior with nothing enabled: stray sample, reads of a cleared store,
  // the unused opcode and a tick that advances at once.
  task automatic test_idle_items();
    write_enable_mask('0);
    send_item(OP_SAMPLE, 16'h8000, 5'd31);
    send_item(OP_READ,   16'h7FFF, 5'd0);
    send_item(OP_READ,   16'h0000, 5'd31);
    send_item(OP_SPARE,  16'hFFFF, 5'd31);
    send_item(OP_TICK,   16'h0000, 5'd0);
    drain_results();
  endtask

  // One channel at one position: a busy tick, a window of extreme samples,
  // then read back the stored median.
  task automatic test_single_channel_scan();
    logic [IDX_W-1:0] slot;
    slot = {2'd1, sim_pos};
    write_enable_mask(32'd1 << slot);
    send_item(OP_TICK,   16'h0000, 5'd0);
    send_item(OP_TICK,   16'hFFFF, 5'd31);
    send_item(OP_SAMPLE, 16'h7FFF, 5'd0);
    send_item(OP_SAMPLE, 16'h8000, 5'd0);
    send_item(OP_SAMPLE, 16'h0005, 5'd0);
    send_item(OP_SAMPLE, 16'hFFFB, 5'd0);
    send_item(OP_SAMPLE, 16'h7FFF, 5'd0);
    send_item(OP_SAMPLE, 16'h8000, 5'd0);
    send_item(OP_SAMPLE, 16'h1234, 5'd0);
    send_item(OP_READ,   16'h0000, slot);
    drain_results();
  endtask

  // Rewrite the mask while a channel is one sample short of a full window; the next channel must
  // come from the new mask.
  task automatic test_mask_change_mid_scan();
    logic [POS_W-1:0] pos;
    pos = sim_pos;
    write_enable_mask((32'd1 << pos) | (32'd1 << (MUX_POSITIONS + pos)));
    send_item(OP_TICK, 16'h0000, 5'd0);
    repeat (SAMPLES_PER_READ - 1) send_item(OP_SAMPLE, random_sample(), 5'd0);
    drain_results();
    write_enable_mask(32'd1 << (3 * MUX_POSITIONS + pos));
    send_item(OP_SAMPLE, random_sample(), 5'd0);
    drain_results();
  endtask

  // Mostly well-formed scans with random content, plus noise, and an
  // occasional mask rewrite between drained stretches.
  task automatic run_random_traffic(input int n_items, input int gap_pct,
                                    input int stall_pct, input logic [MASK_W-1:0] first_mask);
    int useful;
    int roll;
    logic [1:0] op;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    drain_results();
    write_enable_mask(first_mask);
    useful = 0;
    while (useful < n_items) begin
      if ($urandom_range(0, 59) == 0) begin
        drain_results();
        write_enable_mask(random_mask());
      end
      roll = $urandom_range(0, 99);
      if (sim_gathering)
        op = (roll < 86) ? OP_SAMPLE : (roll < 92) ? OP_TICK : (roll < 97) ? OP_READ : OP_SPARE;
      else
        op = (roll < 55) ? OP_TICK : (roll < 82) ? OP_READ : (roll < 92) ? OP_SAMPLE : OP_SPARE;
      // Ignored items do not count toward the stretch length.
      if (!((op == OP_TICK && sim_gathering) || (op == OP_SAMPLE && !sim_gathering) ||
            op == OP_SPARE))
        useful++;
      send_item(op, random_sample(), IDX_W'($urandom_range(0, STORE_DEPTH - 1)));
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_idle_items();
    test_single_channel_scan();
    test_mask_change_mid_scan();

    run_random_traffic(266, 11, 73, '1);
    run_random_traffic(267, 73, 11, $urandom());
    run_random_traffic(267, 0, 0, $urandom() & $urandom());

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d checked results: %0d medians stored,",
             items_sent, results_checked, medians_stored);
    $display("%0d positions finished, %0d enable_mask writes, %0d mismatches",
             positions_done, mask_writes, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### mux_scan_median_sampler_top.f
+incdir+src
src/msms_pkg.sv
src/msms_ram.sv
src/msms_median.sv
src/mux_scan_median_sampler_top.sv
bench/tb_mux_scan_median_sampler_top.sv
